// ----- hdl/xpbd_pkg.sv -----
// Shared types, constants and a helper function of the edge constraint solver.
package xpbd_pkg;

   // Store sizes and the address widths that follow from them.
   localparam int PARTICLES = 1024;
   localparam int EDGES     = 4096;
   localparam int PART_AW   = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
   localparam int EDGE_AW   = (EDGES > 1) ? $clog2(EDGES) : 1;

   // Field widths.
   localparam int IDX_W      = 10;
   localparam int EDGE_IDX_W = 12;
   localparam int POS_W      = 32;
   localparam int MASS_W     = 24;
   localparam int ALPHA_W    = 32;
   localparam int REST_W     = 32;
   localparam int PART_DW    = 3 * POS_W + MASS_W;

   // Register port.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_ALPHA_WORD = 1'b0;

   // Datapath widths.
   localparam int DABS_W = 32;   // magnitude of a coordinate difference
   localparam int LEN_W  = 33;   // edge length
   localparam int SQ_W   = 66;   // sum of squares
   localparam int MUL_W  = 33;   // multiplier operand
   localparam int PROD_W = 66;   // multiplier product
   localparam int BASE_W = 65;   // |C| * |d|
   localparam int NUM_W  = 90;   // dividend
   localparam int QUO_W  = 34;   // quotient bits produced
   localparam int REM_W  = 66;   // divider remainder
   localparam int SQR_W  = 35;   // square root remainder
   localparam int C_W    = 34;   // signed constraint value
   localparam int DEN_W  = 33;   // w1 + w2 + alpha
   localparam int SUM_W  = 36;   // coordinate plus correction

   // Iteration counts.
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int DIV_STEPS  = QUO_W;
   localparam int CNT_W      = 6;

   // Opcodes.
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_REST  = 2'd2;
   localparam logic [1:0] OP_SOLVE = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FIXED = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;

   // Multiplier operand selections.
   localparam logic [2:0] MUL_NONE = 3'd0;
   localparam logic [2:0] MUL_SQ   = 3'd1;
   localparam logic [2:0] MUL_DD   = 3'd2;
   localparam logic [2:0] MUL_BASE = 3'd3;
   localparam logic [2:0] MUL_LO   = 3'd4;
   localparam logic [2:0] MUL_HI   = 3'd5;

   typedef struct packed {
      logic [1:0]              opcode;
      logic [IDX_W-1:0]        first_particle;
      logic [IDX_W-1:0]        second_particle;
      logic [EDGE_IDX_W-1:0]   edge_index;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [MASS_W-1:0]       recip_mass;
   } xpbd_req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] read_x;
      logic signed [POS_W-1:0] read_y;
      logic signed [POS_W-1:0] read_z;
      logic [1:0]              status;
      logic signed [POS_W-1:0] constraint_error;
   } xpbd_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       req_load;
      logic       wr_req;
      logic       rd_part;
      logic       rd_b;
      logic       read_load;
      logic       load_a;
      logic       load_b;
      logic       diff;
      logic [1:0] k;
      logic       psel;
      logic [2:0] mul_sel;
      logic       acc_load;
      logic       acc_add;
      logic       sqrt_step;
      logic       eval;
      logic       check;
      logic       rest_wr;
      logic       dd_load;
      logic       base_load;
      logic       num_lo;
      logic       num_hi;
      logic       div_init;
      logic       div_step;
      logic       upd;
      logic       wr_upd;
   } xpbd_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fixed;
      logic zero;
   } xpbd_stat_type;

   // Clamp a signed value to the signed Q16.16 range.
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi_lim;
      logic signed [SUM_W-1:0] lo_lim;
      hi_lim = 36'sh07FFFFFFF;
      lo_lim = 36'shF80000000;
      if (v > hi_lim) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo_lim) begin
         return 32'sh80000000;
      end
      return v[POS_W-1:0];
   endfunction

endpackage

// ----- hdl/xpbd_ram.sv -----
// Generic single-write, single-read memory with registered read data.
module xpbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/xpbd_datapath.sv -----
// Datapath: particle and rest length stores, multiplier, square root and divider.
module xpbd_datapath (
   input  logic                           clock,
   input  xpbd_pkg::xpbd_cmd_type         cmd,
   input  xpbd_pkg::xpbd_req_type         req_data,
   input  logic [xpbd_pkg::ALPHA_W-1:0]   alpha,
   output xpbd_pkg::xpbd_stat_type        stat,
   output xpbd_pkg::xpbd_rsp_type         rsp_data
);
   import xpbd_pkg::*;

   xpbd_req_type            req_ff;
   xpbd_rsp_type            rsp_ff;
   logic signed [POS_W-1:0] p1_ff [3];
   logic signed [POS_W-1:0] p2_ff [3];
   logic [MASS_W-1:0]       w1_ff;
   logic [MASS_W-1:0]       w2_ff;
   logic [REST_W-1:0]       rest_ff;
   logic [DABS_W-1:0]       dabs_ff [3];
   logic                    dneg_ff [3];
   logic [PROD_W-1:0]       prod_ff;
   logic [SQ_W-1:0]         acc_ff;
   logic [SQR_W-1:0]        sq_rem_ff;
   logic [LEN_W-1:0]        root_ff;
   logic                    c_neg_ff;
   logic [LEN_W-1:0]        ca_ff;
   logic [DEN_W-1:0]        den_ff;
   logic signed [POS_W-1:0] cerr_ff;
   logic                    fixed_ff;
   logic                    zero_ff;
   logic [PROD_W-1:0]       dd_ff;
   logic [BASE_W-1:0]       base_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [REM_W-1:0]        rem_ff;
   logic [QUO_W-1:0]        quo_ff;

   logic                    a_ok;
   logic                    b_ok;
   logic                    e_ok;
   logic [PART_AW-1:0]      a_addr;
   logic [PART_AW-1:0]      b_addr;
   logic [EDGE_AW-1:0]      e_addr;
   logic                    part_we;
   logic [PART_AW-1:0]      part_wa;
   logic [PART_DW-1:0]      part_wd;
   logic [PART_DW-1:0]      part_rd;
   logic [REST_W-1:0]       rest_wd;
   logic [REST_W-1:0]       rest_rd;
   logic signed [POS_W:0]   dvec [3];
   logic [DABS_W-1:0]       dabs_sel;
   logic                    dneg_sel;
   logic signed [POS_W-1:0] p_sel;
   logic [MASS_W-1:0]       w_sel;
   logic [MUL_W-1:0]        mul_a;
   logic [MUL_W-1:0]        mul_b;
   logic [SQR_W+1:0]        sq_r;
   logic [SQR_W+1:0]        sq_trial;
   logic                    sq_ge;
   logic signed [C_W-1:0]   c_val;
   logic [REM_W:0]          dv_r;
   logic                    dv_ge;
   logic                    flip;
   logic signed [SUM_W-1:0] upd_step;
   logic signed [POS_W-1:0] upd_pos;

   // Index range checks and store addresses.
   assign a_ok   = 32'(req_ff.first_particle) < PARTICLES;
   assign b_ok   = 32'(req_ff.second_particle) < PARTICLES;
   assign e_ok   = 32'(req_ff.edge_index) < EDGES;
   assign a_addr = PART_AW'(req_ff.first_particle);
   assign b_addr = PART_AW'(req_ff.second_particle);
   assign e_addr = EDGE_AW'(req_ff.edge_index);

   // Particle store write port: a new particle or an updated one.
   assign part_we = (cmd.wr_req && a_ok) || (cmd.wr_upd && (cmd.psel ? b_ok : a_ok));
   assign part_wa = (cmd.wr_upd && cmd.psel) ? b_addr : a_addr;
   always_comb begin
      if (cmd.wr_req) begin
         part_wd = {req_ff.recip_mass, req_ff.pos_z, req_ff.pos_y, req_ff.pos_x};
      end else if (cmd.psel) begin
         part_wd = {w2_ff, p2_ff[2], p2_ff[1], p2_ff[0]};
      end else begin
         part_wd = {w1_ff, p1_ff[2], p1_ff[1], p1_ff[0]};
      end
   end

   xpbd_ram #(.WIDTH(PART_DW), .DEPTH(PARTICLES)) u_part_ram (
      .clock   (clock),
      .wr_en   (part_we),
      .wr_addr (part_wa),
      .wr_data (part_wd),
      .rd_en   (cmd.rd_part),
      .rd_addr (cmd.rd_b ? b_addr : a_addr),
      .rd_data (part_rd)
   );

   // Captured rest length saturates to 32 bits.
   assign rest_wd = root_ff[LEN_W-1] ? '1 : root_ff[REST_W-1:0];

   xpbd_ram #(.WIDTH(REST_W), .DEPTH(EDGES)) u_rest_ram (
      .clock   (clock),
      .wr_en   (cmd.rest_wr && e_ok),
      .wr_addr (e_addr),
      .wr_data (rest_wd),
      .rd_en   (cmd.rd_part && !cmd.rd_b),
      .rd_addr (e_addr),
      .rd_data (rest_rd)
   );

   // Coordinate differences of the two particles.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dvec[i] = (POS_W+1)'(p1_ff[i]) - (POS_W+1)'(p2_ff[i]);
      end
   end

   // Per-axis selections for the current step.
   always_comb begin
      case (cmd.k)
         2'd1: begin
            dabs_sel = dabs_ff[1];
            dneg_sel = dneg_ff[1];
            p_sel    = cmd.psel ? p2_ff[1] : p1_ff[1];
         end
         2'd2: begin
            dabs_sel = dabs_ff[2];
            dneg_sel = dneg_ff[2];
            p_sel    = cmd.psel ? p2_ff[2] : p1_ff[2];
         end
         default: begin
            dabs_sel = dabs_ff[0];
            dneg_sel = dneg_ff[0];
            p_sel    = cmd.psel ? p2_ff[0] : p1_ff[0];
         end
      endcase
      w_sel = cmd.psel ? w2_ff : w1_ff;
   end

   // Shared multiplier operand selection.
   always_comb begin
      case (cmd.mul_sel)
         MUL_SQ: begin
            mul_a = MUL_W'(dabs_sel);
            mul_b = MUL_W'(dabs_sel);
         end
         MUL_DD: begin
            mul_a = root_ff;
            mul_b = den_ff;
         end
         MUL_BASE: begin
            mul_a = ca_ff;
            mul_b = MUL_W'(dabs_sel);
         end
         MUL_LO: begin
            mul_a = base_ff[MUL_W-1:0];
            mul_b = MUL_W'(w_sel);
         end
         MUL_HI: begin
            mul_a = MUL_W'(base_ff[BASE_W-1:MUL_W]);
            mul_b = MUL_W'(w_sel);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // One digit of the square root per step.
   assign sq_r     = {sq_rem_ff, acc_ff[SQ_W-1:SQ_W-2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_ge    = sq_r >= sq_trial;

   // Constraint value C = len - rest.
   assign c_val = $signed({1'b0, root_ff}) - $signed({2'b00, rest_ff});

   // One quotient bit of the divider per step.
   assign dv_r  = {rem_ff, quo_ff[QUO_W-1]};
   assign dv_ge = dv_r >= {1'b0, dd_ff};

   // Signed correction and the clamped new coordinate.
   assign flip     = c_neg_ff ^ dneg_sel ^ cmd.psel;
   assign upd_step = flip ? $signed({2'b00, quo_ff}) : -$signed({2'b00, quo_ff});
   assign upd_pos  = sat_pos(SUM_W'(p_sel) + upd_step);

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);

      if (cmd.req_load) begin
         req_ff <= req_data;
         rsp_ff <= '0;
      end

      if (cmd.read_load) begin
         rsp_ff.read_x <= a_ok ? part_rd[POS_W-1:0] : '0;
         rsp_ff.read_y <= a_ok ? part_rd[2*POS_W-1:POS_W] : '0;
         rsp_ff.read_z <= a_ok ? part_rd[3*POS_W-1:2*POS_W] : '0;
      end

      if (cmd.load_a) begin
         for (int i = 0; i < 3; i++) begin
            p1_ff[i] <= a_ok ? part_rd[i*POS_W +: POS_W] : '0;
         end
         w1_ff <= a_ok ? part_rd[PART_DW-1:3*POS_W] : '0;
      end

      if (cmd.load_b) begin
         for (int i = 0; i < 3; i++) begin
            p2_ff[i] <= b_ok ? part_rd[i*POS_W +: POS_W] : '0;
         end
         w2_ff   <= b_ok ? part_rd[PART_DW-1:3*POS_W] : '0;
         rest_ff <= e_ok ? rest_rd : '0;
      end

      // Differences, and a fresh start for the square root.
      if (cmd.diff) begin
         for (int i = 0; i < 3; i++) begin
            dneg_ff[i] <= dvec[i][POS_W];
            dabs_ff[i] <= dvec[i][POS_W] ? DABS_W'(-dvec[i]) : dvec[i][DABS_W-1:0];
         end
         sq_rem_ff <= '0;
         root_ff   <= '0;
      end

      // Sum of squares, then consumed two bits at a time by the root.
      if (cmd.acc_load) begin
         acc_ff <= prod_ff;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod_ff;
      end else if (cmd.sqrt_step) begin
         acc_ff <= acc_ff << 2;
      end

      if (cmd.sqrt_step) begin
         sq_rem_ff <= sq_ge ? SQR_W'(sq_r - sq_trial) : SQR_W'(sq_r);
         root_ff   <= {root_ff[LEN_W-2:0], sq_ge};
      end

      // Constraint terms and the skip conditions.
      if (cmd.eval) begin
         c_neg_ff <= c_val[C_W-1];
         ca_ff    <= c_val[C_W-1] ? LEN_W'(-c_val) : c_val[LEN_W-1:0];
         den_ff   <= DEN_W'(w1_ff) + DEN_W'(w2_ff) + DEN_W'(alpha);
         cerr_ff  <= sat_pos(SUM_W'(c_val));
         fixed_ff <= (w1_ff == '0) && (w2_ff == '0);
         zero_ff  <= root_ff == '0;
      end

      if (cmd.check) begin
         if (fixed_ff) begin
            rsp_ff.status <= ST_FIXED;
         end else if (zero_ff) begin
            rsp_ff.status <= ST_ZERO;
         end else begin
            rsp_ff.status           <= ST_DONE;
            rsp_ff.constraint_error <= cerr_ff;
         end
      end

      if (cmd.dd_load) begin
         dd_ff <= prod_ff;
      end
      if (cmd.base_load) begin
         base_ff <= prod_ff[BASE_W-1:0];
      end

      // Dividend |C| * |d| * w from two partial products.
      if (cmd.num_lo) begin
         num_ff <= NUM_W'(prod_ff);
      end else if (cmd.num_hi) begin
         num_ff <= num_ff + (NUM_W'(prod_ff) << MUL_W);
      end

      // Restoring division; the quotient shifts in where the dividend leaves.
      if (cmd.div_init) begin
         rem_ff <= REM_W'(num_ff[NUM_W-1:QUO_W]);
         quo_ff <= num_ff[QUO_W-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= dv_ge ? REM_W'(dv_r - {1'b0, dd_ff}) : dv_r[REM_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], dv_ge};
      end

      // Apply the correction to one coordinate.
      if (cmd.upd) begin
         for (int i = 0; i < 3; i++) begin
            if (cmd.k == 2'(i)) begin
               if (cmd.psel) begin
                  p2_ff[i] <= upd_pos;
               end else begin
                  p1_ff[i] <= upd_pos;
               end
            end
         end
      end
   end

   assign stat.fixed = fixed_ff;
   assign stat.zero  = zero_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- hdl/xpbd_ctrl.sv -----
// Controller state machine that sequences the datapath for each item.
module xpbd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              opcode,
   input  xpbd_pkg::xpbd_stat_type stat,
   output xpbd_pkg::xpbd_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_valid
);
   import xpbd_pkg::*;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_WRITE    = 5'd1;
   localparam logic [4:0] S_RD_A     = 5'd2;
   localparam logic [4:0] S_READ_LD  = 5'd3;
   localparam logic [4:0] S_RD_B     = 5'd4;
   localparam logic [4:0] S_LD_B     = 5'd5;
   localparam logic [4:0] S_DIFF     = 5'd6;
   localparam logic [4:0] S_SQ       = 5'd7;
   localparam logic [4:0] S_SQRT     = 5'd8;
   localparam logic [4:0] S_EVAL     = 5'd9;
   localparam logic [4:0] S_CHECK    = 5'd10;
   localparam logic [4:0] S_DD       = 5'd11;
   localparam logic [4:0] S_DD_LD    = 5'd12;
   localparam logic [4:0] S_BASE     = 5'd13;
   localparam logic [4:0] S_BASE_LD  = 5'd14;
   localparam logic [4:0] S_MLO      = 5'd15;
   localparam logic [4:0] S_MHI      = 5'd16;
   localparam logic [4:0] S_MSUM     = 5'd17;
   localparam logic [4:0] S_DIV_INIT = 5'd18;
   localparam logic [4:0] S_DIV      = 5'd19;
   localparam logic [4:0] S_UPD      = 5'd20;
   localparam logic [4:0] S_WR_A     = 5'd21;
   localparam logic [4:0] S_WR_B     = 5'd22;
   localparam logic [4:0] S_DONE     = 5'd23;

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       k_ff, k_in;
   logic             psel_ff, psel_in;
   logic [1:0]       op_ff, op_in;

   // Next state and command decode.
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      psel_in     = psel_ff;
      op_in       = op_ff;
      cmd         = '0;
      cmd.k       = k_ff;
      cmd.psel    = psel_ff;
      cmd.mul_sel = MUL_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.req_load = 1'b1;
               op_in        = opcode;
               state_in     = (opcode == OP_WRITE) ? S_WRITE : S_RD_A;
            end
         end
         S_WRITE: begin
            cmd.wr_req = 1'b1;
            state_in   = S_DONE;
         end
         S_RD_A: begin
            cmd.rd_part = 1'b1;
            state_in    = (op_ff == OP_READ) ? S_READ_LD : S_RD_B;
         end
         S_READ_LD: begin
            cmd.read_load = 1'b1;
            state_in      = S_DONE;
         end
         S_RD_B: begin
            cmd.rd_part = 1'b1;
            cmd.rd_b    = 1'b1;
            cmd.load_a  = 1'b1;
            state_in    = S_LD_B;
         end
         S_LD_B: begin
            cmd.load_b = 1'b1;
            state_in   = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            cnt_in   = '0;
            state_in = S_SQ;
         end
         // Squares go through the multiplier one axis a cycle.
         S_SQ: begin
            cmd.mul_sel  = MUL_SQ;
            cmd.k        = cnt_ff[1:0];
            cmd.acc_load = cnt_ff == CNT_W'(1);
            cmd.acc_add  = cnt_ff >= CNT_W'(2);
            if (cnt_ff == CNT_W'(3)) begin
               cnt_in   = '0;
               state_in = S_SQRT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               state_in = S_EVAL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            k_in    = '0;
            psel_in = 1'b0;
            if (op_ff == OP_REST) begin
               cmd.rest_wr = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.check = 1'b1;
               state_in  = (stat.fixed || stat.zero) ? S_DONE : S_DD;
            end
         end
         S_DD: begin
            cmd.mul_sel = MUL_DD;
            state_in    = S_DD_LD;
         end
         S_DD_LD: begin
            cmd.dd_load = 1'b1;
            state_in    = S_BASE;
         end
         S_BASE: begin
            cmd.mul_sel = MUL_BASE;
            state_in    = S_BASE_LD;
         end
         S_BASE_LD: begin
            cmd.base_load = 1'b1;
            state_in      = S_MLO;
         end
         S_MLO: begin
            cmd.mul_sel = MUL_LO;
            state_in    = S_MHI;
         end
         S_MHI: begin
            cmd.mul_sel = MUL_HI;
            cmd.num_lo  = 1'b1;
            state_in    = S_MSUM;
         end
         S_MSUM: begin
            cmd.num_hi = 1'b1;
            state_in   = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_UPD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         // Second particle of this axis, next axis, or write back.
         S_UPD: begin
            cmd.upd = 1'b1;
            if (!psel_ff) begin
               psel_in  = 1'b1;
               state_in = S_MLO;
            end else begin
               psel_in = 1'b0;
               if (k_ff == 2'd2) begin
                  state_in = S_WR_A;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_BASE;
               end
            end
         end
         S_WR_A: begin
            cmd.wr_upd = 1'b1;
            cmd.psel   = 1'b0;
            state_in   = S_WR_B;
         end
         S_WR_B: begin
            cmd.wr_upd = 1'b1;
            cmd.psel   = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         k_ff     <= '0;
         psel_ff  <= 1'b0;
         op_ff    <= OP_WRITE;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         psel_ff  <= psel_in;
         op_ff    <= op_in;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_DONE;

endmodule

// ----- hdl/xpbd_edge_constraint_solver_core.sv -----
// Top level of the edge distance constraint solver.
//
//  Channel  Ports                                   Transfer
//  request  start, busy, req_data                   start && !busy
//  result   rsp_valid, rsp_data                     one-cycle strobe
//  config   psel, penable, pwrite, paddr, pwdata,   psel && penable && pready
//           prdata, pready
//
// Capture rest length and a skipped edge are dominated by the 33-step square root.
// A solved edge is dominated by six passes of the 34-step shared divider.
// Synchronous active-high reset clears control and alpha; the stores keep their data.
// The result is shown for one cycle and busy falls in the next.
module xpbd_edge_constraint_solver_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  xpbd_pkg::xpbd_req_type        req_data,
   output logic                          busy,
   output logic                          rsp_valid,
   output xpbd_pkg::xpbd_rsp_type        rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [xpbd_pkg::CSR_AW-1:0]   paddr,
   input  logic [xpbd_pkg::CSR_DW-1:0]   pwdata,
   output logic [xpbd_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import xpbd_pkg::*;

   logic [ALPHA_W-1:0] alpha_ff;
   logic               alpha_hit;
   xpbd_cmd_type       cmd;
   xpbd_stat_type      stat;

   // Register port: the alpha word.
   assign pready    = 1'b1;
   assign alpha_hit = paddr[CSR_AW-1:2] == CSR_ALPHA_WORD;
   assign prdata    = alpha_hit ? alpha_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= '0;
      end else if (psel && penable && pwrite && pready && alpha_hit) begin
         alpha_ff <= pwdata;
      end
   end

   xpbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .opcode    (req_data.opcode),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   xpbd_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .alpha    (alpha_ff),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ----- hdl/xpbd_checker.sv -----
// Port-level checks of the solver top level and their binding.
module xpbd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input xpbd_pkg::xpbd_rsp_type rsp_data,
   input logic                   pready
);
   import xpbd_pkg::*;

   // An accepted item makes the block busy.
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("item accepted but block not busy");

   // A result appears only while an item is in flight.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result without an item in flight");

   // Exactly one result per item: the block is free right after it.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !busy && !rsp_valid)
      else $error("result not followed by idle");

   // Status carries only defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_DONE || rsp_data.status == ST_FIXED ||
                     rsp_data.status == ST_ZERO))
      else $error("undefined status code");

   // The register port never inserts wait states.
   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("register port not ready");

endmodule

bind xpbd_edge_constraint_solver_core xpbd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

// ----- bench/tb_top.sv -----
// Testbench for the edge distance constraint solver: directed and random items against a local predictor.
`timescale 1ns / 100ps

module tb_top;
   import xpbd_pkg::*;

   // Byte address of the alpha register on the register port.
   localparam logic [CSR_AW-1:0] ALPHA_ADDR = 3'd0;
   localparam int RANDOM_PHASES = 4;
   localparam int PHASE_ITEMS   = 150;

   logic         clock;
   logic         reset;
   logic         start;
   xpbd_req_type req_data;
   logic         busy;
   logic         rsp_valid;
   xpbd_rsp_type rsp_data;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic         pready;

   xpbd_edge_constraint_solver_core DUT (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data), .busy(busy),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow copy of the particle store, the rest length table and alpha.
   logic signed [POS_W-1:0]  shadow_pos [PARTICLES][3];
   logic [MASS_W-1:0]        shadow_mass [PARTICLES];
   logic [REST_W-1:0]        shadow_rest [EDGES];
   logic [ALPHA_W-1:0]       shadow_alpha;

   xpbd_req_type pending_items [$];
   xpbd_rsp_type expected_rsps [$];
   int  mismatch_count;
   int  idle_left;
   bit  idle_enable;

   always #10 clock = ~clock;

   function automatic logic [127:0] magnitude(input longint v);
      return (v < 0) ? 128'(-v) : 128'(v);
   endfunction

   function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[POS_W-1:0];
   endfunction

   function automatic logic [127:0] floor_root(input logic [127:0] v);
      logic [127:0] r;
      logic [127:0] c;
      r = '0;
      for (int b = 32; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   // Applies one item to the shadow state and returns the result it should produce.
   function automatic xpbd_rsp_type solve_item(input xpbd_req_type it);
      xpbd_rsp_type r;
      longint p1 [3];
      longint p2 [3];
      longint d [3];
      longint c;
      longint s1;
      longint s2;
      logic [127:0] sq, len, w1, w2, dd, ca, da, base, q1, q2;
      bit neg;
      r = '0;
      case (it.opcode)
         OP_WRITE: begin
            shadow_pos[it.first_particle][0] = it.pos_x;
            shadow_pos[it.first_particle][1] = it.pos_y;
            shadow_pos[it.first_particle][2] = it.pos_z;
            shadow_mass[it.first_particle] = it.recip_mass;
         end
         OP_READ: begin
            r.read_x = shadow_pos[it.first_particle][0];
            r.read_y = shadow_pos[it.first_particle][1];
            r.read_z = shadow_pos[it.first_particle][2];
         end
         default: begin
            sq = '0;
            for (int k = 0; k < 3; k++) begin
               p1[k] = shadow_pos[it.first_particle][k];
               p2[k] = shadow_pos[it.second_particle][k];
               d[k] = p1[k] - p2[k];
               da = magnitude(d[k]);
               sq = sq + da * da;
            end
            len = floor_root(sq);
            w1 = 128'(shadow_mass[it.first_particle]);
            w2 = 128'(shadow_mass[it.second_particle]);
            if (it.opcode == OP_REST) begin
               shadow_rest[it.edge_index] = (len > 128'hFFFFFFFF) ? '1 : len[31:0];
            end else if (w1 + w2 == 0) begin
               r.status = ST_FIXED;
            end else if (len == 0) begin
               r.status = ST_ZERO;
            end else begin
               // Both corrections come from the positions before the update.
               c = longint'(len) - longint'({32'd0, shadow_rest[it.edge_index]});
               ca = magnitude(c);
               dd = len * (w1 + w2 + 128'(shadow_alpha));
               for (int k = 0; k < 3; k++) begin
                  da = magnitude(d[k]);
                  base = ca * da;
                  q1 = (base * w1) / dd;
                  q2 = (base * w2) / dd;
                  neg = ((c < 0) != (d[k] < 0)) && c != 0 && d[k] != 0;
                  s1 = neg ? longint'(q1) : -longint'(q1);
                  s2 = neg ? -longint'(q2) : longint'(q2);
                  shadow_pos[it.first_particle][k] = clamp_pos(p1[k] + s1);
                  shadow_pos[it.second_particle][k] = clamp_pos(p2[k] + s2);
               end
               r.constraint_error = clamp_pos(c);
            end
         end
      endcase
      return r;
   endfunction

   // Driver: holds start until the item is taken, then pulls the next one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         idle_left <= 0;
      end else if (!(start && busy)) begin
         if (start) begin
            expected_rsps.push_back(solve_item(req_data));
         end
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_data <= pending_items.pop_front();
            start <= 1'b1;
            if (idle_enable && $urandom_range(0, 3) == 0) idle_left <= $urandom_range(1, 19);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobed result must match the oldest expectation.
   always @(posedge clock) begin
      xpbd_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result %h", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.read_x !== want.read_x || rsp_data.read_y !== want.read_y ||
                rsp_data.read_z !== want.read_z || rsp_data.status !== want.status ||
                rsp_data.constraint_error !== want.constraint_error) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: expected x=%h y=%h z=%h st=%0d err=%h", want.read_x,
                           want.read_y, want.read_z, want.status, want.constraint_error);
                  $display("          actual   x=%h y=%h z=%h st=%0d err=%h", rsp_data.read_x,
                           rsp_data.read_y, rsp_data.read_z, rsp_data.status,
                           rsp_data.constraint_error);
               end
            end
         end
      end
   end

   // Stimulus side bookkeeping: which store entries have been written.
   bit written_part [PARTICLES];
   int part_list [$];
   int edge_list [$];
   xpbd_req_type last_solve;
   bit have_solve;

   function automatic xpbd_req_type noise_item(input logic [1:0] op);
      xpbd_req_type it;
      it = $bits(xpbd_req_type)'({$urandom, $urandom, $urandom, $urandom, $urandom});
      it.opcode = op;
      return it;
   endfunction

   task automatic queue_write(input int idx, input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [MASS_W-1:0] w);
      xpbd_req_type it;
      it = noise_item(OP_WRITE);
      it.first_particle = IDX_W'(idx);
      it.pos_x = x;
      it.pos_y = y;
      it.pos_z = z;
      it.recip_mass = w;
      pending_items.push_back(it);
      if (!written_part[idx]) part_list.push_back(idx);
      written_part[idx] = 1'b1;
   endtask

   task automatic queue_edge(input logic [1:0] op, input int a, input int b, input int e);
      xpbd_req_type it;
      it = noise_item(op);
      it.first_particle = IDX_W'(a);
      it.second_particle = IDX_W'(b);
      it.edge_index = EDGE_IDX_W'(e);
      pending_items.push_back(it);
      if (op == OP_REST) edge_list.push_back(e);
   endtask

   task automatic queue_read(input int idx);
      xpbd_req_type it;
      it = noise_item(OP_READ);
      it.first_particle = IDX_W'(idx);
      pending_items.push_back(it);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 65535)
                                        : 32'h80000000 + $urandom_range(0, 65535);
         default: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
      endcase
   endfunction

   function automatic logic [MASS_W-1:0] rand_mass();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return MASS_W'($urandom);
         default: return MASS_W'($urandom_range(1, 24'h03FFFF));
      endcase
   endfunction

   function automatic int pick_part();
      return part_list[$urandom_range(0, part_list.size() - 1)];
   endfunction

   task automatic queue_random_item();
      int sel;
      int a;
      int b;
      sel = $urandom_range(0, 99);
      if (part_list.size() < 2 || sel < 25) begin
         queue_write($urandom_range(0, PARTICLES - 1), rand_coord(), rand_coord(),
                     rand_coord(), rand_mass());
      end else if (sel < 40) begin
         queue_read(pick_part());
      end else if (sel < 58 || edge_list.size() == 0) begin
         queue_edge(OP_REST, pick_part(), pick_part(), $urandom_range(0, EDGES - 1));
      end else if (have_solve && $urandom_range(0, 2) == 0) begin
         // Solving the same edge again walks it toward its rest length.
         pending_items.push_back(last_solve);
      end else begin
         a = pick_part();
         b = ($urandom_range(0, 19) == 0) ? a : pick_part();
         queue_edge(OP_SOLVE, a, b, edge_list[$urandom_range(0, edge_list.size() - 1)]);
         last_solve = pending_items[$];
         have_solve = 1'b1;
      end
   endtask

   // Waits until the block has drained and stands idle.
   task automatic drain();
      while (pending_items.size() != 0 || expected_rsps.size() != 0 || start || busy) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_alpha(input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ALPHA_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      shadow_alpha = value;
   endtask

   // Main sequence: reset, directed items, then random phases at several alpha settings.
   initial begin
      logic [31:0] alpha_set [RANDOM_PHASES];
      clock = 1'b0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      mismatch_count = 0;
      idle_enable = 1'b1;
      have_solve = 1'b0;
      shadow_alpha = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_alpha(32'd0);

      // Fixed pair, then a pair at opposite corners whose rest length saturates.
      queue_write(0, 32'd0, 32'd0, 32'd0, 24'd0);
      queue_write(1, 32'h00010000, 32'd0, 32'd0, 24'd0);
      queue_edge(OP_REST, 0, 1, 0);
      queue_edge(OP_SOLVE, 0, 1, 0);
      queue_write(2, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF);
      queue_write(3, 32'h80000000, 32'h80000000, 32'h80000000, 24'hFFFFFF);
      queue_edge(OP_REST, 2, 3, EDGES - 1);
      queue_edge(OP_SOLVE, 2, 3, EDGES - 1);
      queue_read(2);
      queue_read(3);
      // Same particle twice, and two distinct particles at one point.
      queue_edge(OP_SOLVE, 2, 2, EDGES - 1);
      queue_write(4, 32'h00050000, 32'hFFFF0000, 32'd7, 24'h000001);
      queue_write(5, 32'h00050000, 32'hFFFF0000, 32'd7, 24'h010000);
      queue_edge(OP_SOLVE, 4, 5, 0);
      // A short edge with a huge rest length pushes a particle past the upper limit.
      queue_write(6, 32'h7FFFFFF0, 32'h0, 32'h0, 24'h010000);
      queue_write(1023, 32'h7FFFFF00, 32'h0, 32'h0, 24'h010000);
      queue_edge(OP_SOLVE, 6, 1023, EDGES - 1);
      queue_read(6);
      queue_read(1023);
      // One fixed and one free particle: the free one takes the whole correction.
      queue_edge(OP_SOLVE, 1, 1023, 0);
      queue_read(1023);
      drain();

      alpha_set[0] = 32'hFFFFFFFF;
      alpha_set[1] = 32'h00010000;
      alpha_set[2] = $urandom;
      alpha_set[3] = 32'd0;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_alpha(alpha_set[ph]);
         if (ph == RANDOM_PHASES - 1) idle_enable = 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) queue_random_item();
         drain();
      end
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("** xpbd_edge_constraint_solver_core: PASSED **");
      end else begin
         $display("** xpbd_edge_constraint_solver_core: FAILED **");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #40ms;
      $display("** xpbd_edge_constraint_solver_core: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/xpbd_pkg.sv
hdl/xpbd_ram.sv
hdl/xpbd_datapath.sv
hdl/xpbd_ctrl.sv
hdl/xpbd_edge_constraint_solver_core.sv
hdl/xpbd_checker.sv
bench/tb_top.sv
